/* rtl/core/mtep_pkg.sv */
// shared types and constants for the midi track event parser
// no dependencies; used by midi_track_event_parser
`default_nettype none

package mtep_pkg;

    localparam int POS_BITS   = 20;
    localparam int LEN_BITS   = 20;
    localparam int WIDE_BITS  = 28;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int MAX_RES    = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_STREAM_LENGTH = 2'd0;
    localparam logic [1:0] CFG_SONG_IS_MUSIC = 2'd1;
    localparam logic [1:0] CFG_VOICE_ID      = 2'd2;
    localparam logic [1:0] CFG_REVERB_DEPTH  = 2'd3;

    localparam logic [LEN_BITS-1:0] STREAM_LENGTH_RST = 20'hFFFFF;
    localparam logic [6:0]          VOICE_ID_RST      = 7'd15;

    // track byte codes
    localparam logic [7:0] STATUS_META = 8'hFF;
    localparam logic [7:0] META_TEXT   = 8'h07;
    localparam logic [7:0] META_END    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_SEQ    = 8'h7F;
    localparam logic [7:0] SEQ_MARK    = 8'h23;
    localparam logic [7:0] SEQ_JUMP    = 8'h20;
    localparam logic [7:0] TEMPO_LEN   = 8'h03;

    // channel event kinds, status high nibble minus 8
    localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_CONTROL  = 3'd3;
    localparam logic [2:0] KIND_PROGRAM  = 3'd4;
    localparam logic [2:0] KIND_PRESSURE = 3'd5;
    localparam logic [2:0] KIND_BEND     = 3'd6;

    typedef enum logic [3:0] {
        EV_DELTA    = 4'd0,
        EV_NOTE_OFF = 4'd1,
        EV_NOTE_ON  = 4'd2,
        EV_REVERB   = 4'd3,
        EV_CONTROL  = 4'd4,
        EV_PROGRAM  = 4'd5,
        EV_PRESSURE = 4'd6,
        EV_BEND     = 4'd7,
        EV_TEMPO    = 4'd8,
        EV_MARK     = 4'd9,
        EV_JUMP     = 4'd10,
        EV_END      = 4'd11,
        EV_ERROR    = 4'd12
    } t_event_code;

    typedef struct packed {
        t_event_code          code;
        logic [6:0]           channel;
        logic [7:0]           first_value;
        logic [7:0]           second_value;
        logic [WIDE_BITS-1:0] wide_value;
        logic                 last;
    } t_result;

    function automatic t_result mk_res(t_event_code code, logic [6:0] channel,
                                       logic [7:0] first_value,
                                       logic [7:0] second_value,
                                       logic [WIDE_BITS-1:0] wide_value);
        t_result r;
        r.code         = code;
        r.channel      = channel;
        r.first_value  = first_value;
        r.second_value = second_value;
        r.wide_value   = wide_value;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/midi_track_event_parser.sv */
// results of a byte are written into the result buffer when the byte is taken and offered from its head
// throughput: one track byte per cycle; each byte gives up to three results,
// drained one per cycle while the receiver is ready, through an eight-entry result buffer,
// and the byte side stalls while fewer than three buffer slots are free
// reset (i_rst_n low, synchronous): parser back to the delta of position zero,
// buffer empty, configuration to its defaults; depends on mtep_pkg
`default_nettype none

module midi_track_event_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // track bytes
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] start_of_track
    // results
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [6:0] channel, [14:7] first_value, [22:15] second_value,
    // [50:23] wide_value, [55:51] zero
    output logic [55:0]      o_m_axis_tdata,
    output logic [3:0]       o_m_axis_tuser,   // [3:0] event_code
    output logic             o_m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    typedef enum logic [4:0] {
        PH_DELTA0, PH_DELTAN, PH_STATUS,
        PH_NOFF_KEY, PH_NON_KEY, PH_NON_VEL,
        PH_CTRL_NUM, PH_CTRL_VAL, PH_PROG, PH_PRESS, PH_BEND1, PH_BEND2,
        PH_META_TYPE, PH_TEXT_LEN, PH_TEXT_SKIP, PH_END_LEN,
        PH_TEMPO_LEN, PH_TEMPO0, PH_TEMPO1, PH_TEMPO2,
        PH_SEQ_LEN, PH_SEQ_MAN, PH_SEQ_TYPE, PH_JUMP1, PH_JUMP2
    } t_phase;

    localparam int PB = mtep_pkg::POS_BITS;
    localparam int WB = mtep_pkg::WIDE_BITS;
    localparam int AW = mtep_pkg::FIFO_AW;
    localparam int CW = AW + 1;

    // configuration
    logic [mtep_pkg::LEN_BITS-1:0] r_stream_length;
    logic                          r_song_is_music;
    logic [6:0]                    r_voice_id;
    logic [6:0]                    r_reverb_depth;

    // parser state
    t_phase        r_phase,      n_phase;
    logic [PB-1:0] r_pos,        n_pos;
    logic [PB-1:0] r_mark_pos,   n_mark_pos;
    logic          r_mark_valid, n_mark_valid;
    logic [WB-1:0] r_delta,      n_delta;
    logic [1:0]    r_delta_cnt,  n_delta_cnt;
    logic [6:0]    r_chan,       n_chan;
    logic [7:0]    r_held,       n_held;
    logic [7:0]    r_skip,       n_skip;
    logic [23:0]   r_tempo,      n_tempo;
    logic          r_ended,      n_ended;

    // result buffer
    mtep_pkg::t_result r_fifo [mtep_pkg::FIFO_DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    mtep_pkg::t_result res [mtep_pkg::MAX_RES];
    logic [1:0]        n_res;
    logic              done;
    logic [7:0]        b;
    logic              in_fire;
    logic              out_fire;
    logic [1:0]        push_cnt;
    mtep_pkg::t_result head;

    assign b        = i_s_axis_tdata;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign push_cnt = in_fire ? n_res : 2'd0;

    assign o_s_axis_tready = (r_count <= CW'(mtep_pkg::FIFO_DEPTH - mtep_pkg::MAX_RES));
    assign o_cfg_ready     = 1'b1;

    assign head            = r_fifo[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tuser  = head.code;
    assign o_m_axis_tlast  = head.last;
    assign o_m_axis_tdata  = {5'd0, head.wide_value, head.second_value,
                              head.first_value, head.channel};

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_mark_pos   = r_mark_pos;
        n_mark_valid = r_mark_valid;
        n_delta      = r_delta;
        n_delta_cnt  = r_delta_cnt;
        n_chan       = r_chan;
        n_held       = r_held;
        n_skip       = r_skip;
        n_tempo      = r_tempo;
        n_ended      = r_ended;
        n_res        = 2'd0;
        done         = 1'b0;
        for (int k = 0; k < mtep_pkg::MAX_RES; k++) begin
            res[k] = mtep_pkg::mk_res(mtep_pkg::EV_DELTA, '0, '0, '0, '0);
        end

        if (i_s_axis_tuser) begin
            n_phase      = PH_DELTA0;
            n_pos        = '0;
            n_mark_pos   = '0;
            n_mark_valid = 1'b0;
            n_delta      = '0;
            n_delta_cnt  = '0;
            n_chan       = '0;
            n_held       = '0;
            n_skip       = '0;
            n_tempo      = '0;
            n_ended      = 1'b0;
        end

        if (!n_ended) begin
            if (32'(n_pos) >= 32'(r_stream_length)) begin
                res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_ERROR, '0, '0, '0, '0);
                n_res      = n_res + 2'd1;
                n_ended    = 1'b1;
            end else begin
                n_pos = n_pos + PB'(1);
                unique case (n_phase)
                    PH_DELTA0: begin
                        if (b[7]) begin
                            n_delta     = WB'(b[6:0]);
                            n_delta_cnt = 2'd0;
                            n_phase     = PH_DELTAN;
                        end else begin
                            n_delta    = WB'(b);
                            res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_DELTA, '0, '0, '0,
                                                          WB'(b));
                            n_res      = n_res + 2'd1;
                            n_phase    = PH_STATUS;
                        end
                    end
                    PH_DELTAN: begin
                        n_delta     = {n_delta[WB-8:0], b[6:0]};
                        n_delta_cnt = n_delta_cnt + 2'd1;
                        if (!b[7] || n_delta_cnt == 2'd3) begin
                            res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_DELTA, '0, '0, '0,
                                                          n_delta);
                            n_res      = n_res + 2'd1;
                            n_phase    = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        if (b == mtep_pkg::STATUS_META) begin
                            n_phase = PH_META_TYPE;
                        end else if (b[7] && (b[6:4] != 3'd7)) begin
                            n_chan = r_song_is_music ? {3'd0, b[3:0]} : r_voice_id;
                            unique case (b[6:4])
                                mtep_pkg::KIND_NOTE_OFF: n_phase = PH_NOFF_KEY;
                                mtep_pkg::KIND_NOTE_ON:  n_phase = PH_NON_KEY;
                                mtep_pkg::KIND_CONTROL:  n_phase = PH_CTRL_NUM;
                                mtep_pkg::KIND_PROGRAM:  n_phase = PH_PROG;
                                mtep_pkg::KIND_PRESSURE: n_phase = PH_PRESS;
                                mtep_pkg::KIND_BEND:     n_phase = PH_BEND1;
                                default:                 done    = 1'b1;
                            endcase
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_NOFF_KEY: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_NOTE_OFF, n_chan, b, '0,
                                                      '0);
                        n_res      = n_res + 2'd1;
                        done       = 1'b1;
                    end
                    PH_NON_KEY: begin
                        n_held  = b;
                        n_phase = PH_NON_VEL;
                    end
                    PH_NON_VEL: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_REVERB, r_voice_id,
                                                      {1'b0, r_reverb_depth}, '0, '0);
                        n_res      = n_res + 2'd1;
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_NOTE_ON, n_chan, n_held,
                                                      b, '0);
                        n_res      = n_res + 2'd1;
                        done       = 1'b1;
                    end
                    PH_CTRL_NUM: begin
                        n_held  = b;
                        n_phase = PH_CTRL_VAL;
                    end
                    PH_CTRL_VAL: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_CONTROL, n_chan, n_held,
                                                      b, '0);
                        n_res      = n_res + 2'd1;
                        done       = 1'b1;
                    end
                    PH_PROG: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_PROGRAM, n_chan, b, '0,
                                                      '0);
                        n_res      = n_res + 2'd1;
                        done       = 1'b1;
                    end
                    PH_PRESS: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_PRESSURE, n_chan, b, '0,
                                                      '0);
                        n_res      = n_res + 2'd1;
                        done       = 1'b1;
                    end
                    PH_BEND1: begin
                        n_held  = b;
                        n_phase = PH_BEND2;
                    end
                    PH_BEND2: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_BEND, n_chan, '0, '0,
                                                      WB'({b, n_held[7:1]}));
                        n_res      = n_res + 2'd1;
                        done       = 1'b1;
                    end
                    PH_META_TYPE: begin
                        priority if (b == mtep_pkg::META_TEXT)  n_phase = PH_TEXT_LEN;
                        else if (b == mtep_pkg::META_END)       n_phase = PH_END_LEN;
                        else if (b == mtep_pkg::META_TEMPO)     n_phase = PH_TEMPO_LEN;
                        else if (b == mtep_pkg::META_SEQ)       n_phase = PH_SEQ_LEN;
                        else                                    done    = 1'b1;
                    end
                    PH_TEXT_LEN: begin
                        n_skip = b;
                        if (b == 8'd0) begin
                            done = 1'b1;
                        end else begin
                            n_phase = PH_TEXT_SKIP;
                        end
                    end
                    PH_TEXT_SKIP: begin
                        n_skip = n_skip - 8'd1;
                        if (n_skip == 8'd0) begin
                            done = 1'b1;
                        end
                    end
                    PH_END_LEN: begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_END, '0, '0, '0, '0);
                        n_res      = n_res + 2'd1;
                        n_ended    = 1'b1;
                    end
                    PH_TEMPO_LEN: begin
                        if (b == mtep_pkg::TEMPO_LEN) begin
                            n_phase = PH_TEMPO0;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_TEMPO0: begin
                        n_tempo = {16'd0, b};
                        n_phase = PH_TEMPO1;
                    end
                    PH_TEMPO1: begin
                        n_tempo = {n_tempo[15:0], b};
                        n_phase = PH_TEMPO2;
                    end
                    PH_TEMPO2: begin
                        n_tempo = {n_tempo[15:0], b};
                        if (n_tempo != 24'd0) begin
                            res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_TEMPO, '0, '0, '0,
                                                          WB'(n_tempo));
                            n_res      = n_res + 2'd1;
                        end
                        done = 1'b1;
                    end
                    PH_SEQ_LEN: begin
                        n_phase = PH_SEQ_MAN;
                    end
                    PH_SEQ_MAN: begin
                        if (b == 8'd0) begin
                            n_phase = PH_SEQ_TYPE;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_SEQ_TYPE: begin
                        priority if (b == mtep_pkg::SEQ_MARK) begin
                            n_mark_pos   = n_pos;
                            n_mark_valid = 1'b1;
                            res[n_res]   = mtep_pkg::mk_res(mtep_pkg::EV_MARK, '0, '0, '0,
                                                            WB'(n_pos));
                            n_res        = n_res + 2'd1;
                            done         = 1'b1;
                        end else if (b == mtep_pkg::SEQ_JUMP) begin
                            n_phase = PH_JUMP1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_JUMP1: begin
                        n_phase = PH_JUMP2;
                    end
                    PH_JUMP2: begin
                        if (n_mark_valid) begin
                            n_pos      = n_mark_pos;
                            res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_JUMP, '0, '0, '0,
                                                          WB'(n_mark_pos));
                            n_res      = n_res + 2'd1;
                        end
                        done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_DELTA0;
                    end
                endcase

                if (done) begin
                    if (32'(n_pos) >= 32'(r_stream_length)) begin
                        res[n_res] = mtep_pkg::mk_res(mtep_pkg::EV_END, '0, '0, '0, '0);
                        n_res      = n_res + 2'd1;
                        n_ended    = 1'b1;
                    end else begin
                        n_phase = PH_DELTA0;
                    end
                end
            end
        end

        if (n_res != 2'd0) begin
            res[n_res - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= mtep_pkg::STREAM_LENGTH_RST;
            r_song_is_music <= 1'b1;
            r_voice_id      <= mtep_pkg::VOICE_ID_RST;
            r_reverb_depth  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mtep_pkg::CFG_STREAM_LENGTH: r_stream_length <= i_cfg_data;
                mtep_pkg::CFG_SONG_IS_MUSIC: r_song_is_music <= i_cfg_data[0];
                mtep_pkg::CFG_VOICE_ID:      r_voice_id      <= i_cfg_data[6:0];
                mtep_pkg::CFG_REVERB_DEPTH:  r_reverb_depth  <= i_cfg_data[6:0];
                default:                     r_reverb_depth  <= r_reverb_depth;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_DELTA0;
            r_pos        <= '0;
            r_mark_pos   <= '0;
            r_mark_valid <= 1'b0;
            r_delta      <= '0;
            r_delta_cnt  <= '0;
            r_chan       <= '0;
            r_held       <= '0;
            r_skip       <= '0;
            r_tempo      <= '0;
            r_ended      <= 1'b0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_mark_pos   <= n_mark_pos;
            r_mark_valid <= n_mark_valid;
            r_delta      <= n_delta;
            r_delta_cnt  <= n_delta_cnt;
            r_chan       <= n_chan;
            r_held       <= n_held;
            r_skip       <= n_skip;
            r_tempo      <= n_tempo;
            r_ended      <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(push_cnt);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(push_cnt) - CW'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mtep_pkg::MAX_RES; k++) begin
            if (k < int'(push_cnt)) begin
                r_fifo[r_wr_ptr + AW'(k)] <= res[k];
            end
        end
    end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// self-checking bench for midi_track_event_parser: directed and random track bytes
// with a built-in parse predictor; depends on mtep_pkg and the parser rtl

module tb_top;
    import mtep_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] KIND_POLY_AT = 3'd2;
    localparam logic [2:0] KIND_SYSTEM  = 3'd7;

    typedef enum logic [4:0] {
        P_DELTA_FIRST, P_DELTA_MORE, P_STATUS, P_NOFF_KEY, P_NON_KEY, P_NON_VEL,
        P_CTRL_NUM, P_CTRL_VAL, P_PROG, P_PRESS, P_BEND_LSB, P_BEND_MSB,
        P_META_TYPE, P_TEXT_LEN, P_TEXT_SKIP, P_END_LEN, P_TEMPO_LEN,
        P_TEMPO_HI, P_TEMPO_MID, P_TEMPO_LO, P_SEQ_LEN, P_SEQ_MAN, P_SEQ_TYPE,
        P_JUMP_A, P_JUMP_B
    } t_parse_phase;

    typedef struct {
        logic [7:0] data;
        logic       sot;
        int         gap;
    } t_track_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;
    logic [3:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [19:0] i_cfg_data = 20'd0;

    midi_track_event_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor copy of configuration and parse state
    logic [LEN_BITS-1:0]  cfg_length;
    logic                 cfg_music;
    logic [6:0]           cfg_voice;
    logic [6:0]           cfg_reverb;
    t_parse_phase         phase;
    logic [POS_BITS-1:0]  pos;
    logic [POS_BITS-1:0]  mark_pos;
    logic                 mark_ok;
    logic [WIDE_BITS-1:0] delta_acc;
    logic [1:0]           delta_cnt;
    logic [6:0]           ev_chan;
    logic [7:0]           held_byte;
    logic [7:0]           skip_left;
    logic [23:0]          tempo_acc;
    logic                 ended;

    t_result     expected_events[$];
    t_track_item track_bytes[$];
    t_track_item cur_item = '{8'd0, 1'b0, 0};
    bit          staged = 1'b0;
    bit          offering;
    int          gap_left;
    int          gap_max = 16;
    int          pushed = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          rx_stall = 0;
    int          rx_hold = 0;
    int          rx_seen = 0;
    int          holds_asked = 0;
    int          holds_done = 0;

    function automatic t_result make_event(t_event_code code, logic [6:0] ch,
                                           logic [7:0] a, logic [7:0] b,
                                           logic [WIDE_BITS-1:0] w);
        t_result r;
        r.code         = code;
        r.channel      = ch;
        r.first_value  = a;
        r.second_value = b;
        r.wide_value   = w;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic restart_parser();
        phase     = P_DELTA_FIRST;
        pos       = '0;
        mark_pos  = '0;
        mark_ok   = 1'b0;
        delta_acc = '0;
        delta_cnt = 2'd0;
        ev_chan   = 7'd0;
        held_byte = 8'd0;
        skip_left = 8'd0;
        tempo_acc = 24'd0;
        ended     = 1'b0;
    endtask

    task automatic parse_track_byte(input logic [7:0] b, input logic sot);
        t_result batch[$];
        logic    done;
        done = 1'b0;
        if (sot) restart_parser();
        if (ended) return;
        if (pos >= cfg_length) begin
            batch.push_back(make_event(EV_ERROR, 7'd0, 8'd0, 8'd0, '0));
            ended = 1'b1;
        end else begin
            pos = pos + POS_BITS'(1);
            case (phase)
                P_DELTA_FIRST: begin
                    if (b[7]) begin
                        delta_acc = {21'd0, b[6:0]};
                        delta_cnt = 2'd0;
                        phase = P_DELTA_MORE;
                    end else begin
                        delta_acc = {20'd0, b};
                        batch.push_back(make_event(EV_DELTA, 7'd0, 8'd0, 8'd0, delta_acc));
                        phase = P_STATUS;
                    end
                end
                P_DELTA_MORE: begin
                    delta_acc = {delta_acc[20:0], 7'd0} + {21'd0, b[6:0]};
                    delta_cnt = delta_cnt + 2'd1;
                    if (!b[7] || delta_cnt == 2'd3) begin
                        batch.push_back(make_event(EV_DELTA, 7'd0, 8'd0, 8'd0, delta_acc));
                        phase = P_STATUS;
                    end
                end
                P_STATUS: begin
                    if (b == STATUS_META) begin
                        phase = P_META_TYPE;
                    end else if (b[7] && b[6:4] != KIND_SYSTEM) begin
                        ev_chan = cfg_music ? {3'd0, b[3:0]} : cfg_voice;
                        case (b[6:4])
                            KIND_NOTE_OFF: phase = P_NOFF_KEY;
                            KIND_NOTE_ON:  phase = P_NON_KEY;
                            KIND_CONTROL:  phase = P_CTRL_NUM;
                            KIND_PROGRAM:  phase = P_PROG;
                            KIND_PRESSURE: phase = P_PRESS;
                            KIND_BEND:     phase = P_BEND_LSB;
                            default:       done = 1'b1;
                        endcase
                    end else begin
                        done = 1'b1;
                    end
                end
                P_NOFF_KEY: begin
                    batch.push_back(make_event(EV_NOTE_OFF, ev_chan, b, 8'd0, '0));
                    done = 1'b1;
                end
                P_NON_KEY: begin
                    held_byte = b;
                    phase = P_NON_VEL;
                end
                P_NON_VEL: begin
                    batch.push_back(make_event(EV_REVERB, cfg_voice, {1'b0, cfg_reverb},
                                               8'd0, '0));
                    batch.push_back(make_event(EV_NOTE_ON, ev_chan, held_byte, b, '0));
                    done = 1'b1;
                end
                P_CTRL_NUM: begin
                    held_byte = b;
                    phase = P_CTRL_VAL;
                end
                P_CTRL_VAL: begin
                    batch.push_back(make_event(EV_CONTROL, ev_chan, held_byte, b, '0));
                    done = 1'b1;
                end
                P_PROG: begin
                    batch.push_back(make_event(EV_PROGRAM, ev_chan, b, 8'd0, '0));
                    done = 1'b1;
                end
                P_PRESS: begin
                    batch.push_back(make_event(EV_PRESSURE, ev_chan, b, 8'd0, '0));
                    done = 1'b1;
                end
                P_BEND_LSB: begin
                    held_byte = b;
                    phase = P_BEND_MSB;
                end
                P_BEND_MSB: begin
                    batch.push_back(make_event(EV_BEND, ev_chan, 8'd0, 8'd0,
                                               {13'd0, b, held_byte[7:1]}));
                    done = 1'b1;
                end
                P_META_TYPE: begin
                    if (b == META_TEXT) phase = P_TEXT_LEN;
                    else if (b == META_END) phase = P_END_LEN;
                    else if (b == META_TEMPO) phase = P_TEMPO_LEN;
                    else if (b == META_SEQ) phase = P_SEQ_LEN;
                    else done = 1'b1;
                end
                P_TEXT_LEN: begin
                    skip_left = b;
                    if (b == 8'd0) done = 1'b1;
                    else phase = P_TEXT_SKIP;
                end
                P_TEXT_SKIP: begin
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0) done = 1'b1;
                end
                P_END_LEN: begin
                    batch.push_back(make_event(EV_END, 7'd0, 8'd0, 8'd0, '0));
                    ended = 1'b1;
                end
                P_TEMPO_LEN: begin
                    if (b == TEMPO_LEN) phase = P_TEMPO_HI;
                    else done = 1'b1;
                end
                P_TEMPO_HI: begin
                    tempo_acc = {16'd0, b};
                    phase = P_TEMPO_MID;
                end
                P_TEMPO_MID: begin
                    tempo_acc = {tempo_acc[15:0], b};
                    phase = P_TEMPO_LO;
                end
                P_TEMPO_LO: begin
                    tempo_acc = {tempo_acc[15:0], b};
                    if (tempo_acc != 24'd0)
                        batch.push_back(make_event(EV_TEMPO, 7'd0, 8'd0, 8'd0,
                                                   {4'd0, tempo_acc}));
                    done = 1'b1;
                end
                P_SEQ_LEN: phase = P_SEQ_MAN;
                P_SEQ_MAN: begin
                    if (b == 8'd0) phase = P_SEQ_TYPE;
                    else done = 1'b1;
                end
                P_SEQ_TYPE: begin
                    if (b == SEQ_MARK) begin
                        mark_pos = pos;
                        mark_ok = 1'b1;
                        batch.push_back(make_event(EV_MARK, 7'd0, 8'd0, 8'd0,
                                                   {8'd0, mark_pos}));
                        done = 1'b1;
                    end else if (b == SEQ_JUMP) begin
                        phase = P_JUMP_A;
                    end else begin
                        done = 1'b1;
                    end
                end
                P_JUMP_A: phase = P_JUMP_B;
                P_JUMP_B: begin
                    if (mark_ok) begin
                        pos = mark_pos;
                        batch.push_back(make_event(EV_JUMP, 7'd0, 8'd0, 8'd0,
                                                   {8'd0, mark_pos}));
                    end
                    done = 1'b1;
                end
                default: phase = P_DELTA_FIRST;
            endcase
            if (done) begin
                if (pos >= cfg_length) begin
                    batch.push_back(make_event(EV_END, 7'd0, 8'd0, 8'd0, '0));
                    ended = 1'b1;
                end else begin
                    phase = P_DELTA_FIRST;
                end
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_events.push_back(batch[i]);
    endtask

    function automatic void check_field(input string name, input logic [27:0] want,
                                        input logic [27:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            staged = 1'b0;
        end else begin
            offering = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                parse_track_byte(i_s_axis_tdata, i_s_axis_tuser);
                offering = 1'b0;
            end
            if (!offering) begin
                if (!staged && track_bytes.size() > 0) begin
                    cur_item = track_bytes.pop_front();
                    gap_left = cur_item.gap;
                    staged = 1'b1;
                end
                if (staged) begin
                    if (gap_left == 0) begin
                        offering = 1'b1;
                        staged = 1'b0;
                    end else begin
                        gap_left--;
                    end
                end
            end
            i_s_axis_tvalid <= offering;
            i_s_axis_tdata  <= cur_item.data;
            i_s_axis_tuser  <= cur_item.sot;
        end
    end

    // result receiver, with per-transaction stalls and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                rx_seen++;
                rx_stall = ((rx_seen / 40) % 3 == 2) ? 0 : int'($urandom_range(0, 16));
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            if (holds_done != holds_asked) begin
                holds_done++;
                rx_hold = 400;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            i_m_axis_tready <= (rx_stall == 0 && rx_hold == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected result: event_code %0d", o_m_axis_tuser);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_code", 28'(want.code), 28'(o_m_axis_tuser));
                check_field("channel", 28'(want.channel), 28'(o_m_axis_tdata[6:0]));
                check_field("first_value", 28'(want.first_value), 28'(o_m_axis_tdata[14:7]));
                check_field("second_value", 28'(want.second_value),
                            28'(o_m_axis_tdata[22:15]));
                check_field("wide_value", want.wide_value, o_m_axis_tdata[50:23]);
                check_field("last", 28'(want.last), 28'(o_m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] status_byte(logic [2:0] kind, logic [3:0] ch);
        return {1'b1, kind, ch};
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic sot = 1'b0);
        t_track_item it;
        it.data = b;
        it.sot  = sot;
        it.gap  = (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
        track_bytes.push_back(it);
        pushed++;
    endtask

    task automatic push_delta(input logic sot);
        int n;
        n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(2, 4)) : 1;
        for (int k = 1; k < n; k++) push_byte({1'b1, 7'($urandom)}, sot && k == 1);
        push_byte((n == 4) ? 8'($urandom) : {1'b0, 7'($urandom)}, sot && n == 1);
    endtask

    task automatic push_event(output bit stop);
        int         pick;
        logic [7:0] val;
        stop = 1'b0;
        pick = int'($urandom_range(0, 29));
        case (pick)
            0, 1, 2, 3: begin
                push_byte(status_byte(KIND_NOTE_ON, 4'($urandom)));
                push_byte(8'($urandom));
                push_byte(8'($urandom));
            end
            4, 5: begin
                push_byte(status_byte(KIND_NOTE_OFF, 4'($urandom)));
                push_byte(8'($urandom));
            end
            6, 7, 8: begin
                push_byte(status_byte(KIND_CONTROL, 4'($urandom)));
                push_byte(8'($urandom));
                push_byte(8'($urandom));
            end
            9, 10: begin
                push_byte(status_byte(KIND_PROGRAM, 4'($urandom)));
                push_byte(8'($urandom));
            end
            11, 12: begin
                push_byte(status_byte(KIND_PRESSURE, 4'($urandom)));
                push_byte(8'($urandom));
            end
            13, 14: begin
                push_byte(status_byte(KIND_BEND, 4'($urandom)));
                push_byte(8'($urandom));
                push_byte(8'($urandom));
            end
            15: push_byte(status_byte(KIND_POLY_AT, 4'($urandom)));
            16: push_byte({1'b0, 7'($urandom)});
            17: push_byte(status_byte(KIND_SYSTEM, 4'($urandom_range(0, 14))));
            18, 19: begin
                push_byte(STATUS_META);
                push_byte(META_TEXT);
                val = 8'($urandom_range(0, 6));
                push_byte(val);
                repeat (val) push_byte(8'($urandom));
            end
            20, 21: begin
                push_byte(STATUS_META);
                push_byte(META_TEMPO);
                if ($urandom_range(0, 4) == 0) begin
                    do val = 8'($urandom); while (val == TEMPO_LEN);
                    push_byte(val);
                end else begin
                    push_byte(TEMPO_LEN);
                    if ($urandom_range(0, 5) == 0) repeat (3) push_byte(8'd0);
                    else repeat (3) push_byte(8'($urandom));
                end
            end
            22: begin
                push_byte(STATUS_META);
                do val = 8'($urandom);
                while (val == META_TEXT || val == META_END || val == META_TEMPO
                       || val == META_SEQ);
                push_byte(val);
            end
            23, 24, 25, 26, 27: begin
                push_byte(STATUS_META);
                push_byte(META_SEQ);
                push_byte(8'($urandom));
                if ($urandom_range(0, 5) == 0) begin
                    push_byte(8'($urandom_range(1, 255)));
                end else begin
                    push_byte(8'd0);
                    case ($urandom_range(0, 4))
                        0, 1: push_byte(SEQ_MARK);
                        2, 3: begin
                            push_byte(SEQ_JUMP);
                            push_byte(8'($urandom));
                            push_byte(8'($urandom));
                        end
                        default: begin
                            do val = 8'($urandom); while (val == SEQ_MARK || val == SEQ_JUMP);
                            push_byte(val);
                        end
                    endcase
                end
            end
            28: begin
                push_byte(STATUS_META);
                push_byte(META_END);
                push_byte(8'($urandom));
                stop = 1'b1;
            end
            default: push_byte(8'($urandom));
        endcase
    endtask

    task automatic push_track(input int n_events);
        bit stop;
        for (int i = 0; i < n_events; i++) begin
            if ($urandom_range(0, 19) == 0) push_byte(8'($urandom), 1'($urandom));
            push_delta(i == 0);
            push_event(stop);
            if (stop) break;
        end
    endtask

    task automatic random_phase(input int n_items, input int gmax);
        int stop_at;
        stop_at = pushed + n_items;
        while (pushed < stop_at) begin
            gap_max = (gmax < 0) ? 16 * int'($urandom_range(0, 1)) : gmax;
            push_track(int'($urandom_range(3, 25)));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STREAM_LENGTH: cfg_length = val;
            CFG_SONG_IS_MUSIC: cfg_music  = val[0];
            CFG_VOICE_ID:      cfg_voice  = val[6:0];
            CFG_REVERB_DEPTH:  cfg_reverb = val[6:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [19:0] len, input logic music,
                             input logic [6:0] voice, input logic [6:0] reverb);
        write_reg(CFG_STREAM_LENGTH, len);
        write_reg(CFG_SONG_IS_MUSIC, {19'd0, music});
        write_reg(CFG_VOICE_ID, {13'd0, voice});
        write_reg(CFG_REVERB_DEPTH, {13'd0, reverb});
    endtask

    task automatic settle();
        while (track_bytes.size() != 0 || staged || i_s_axis_tvalid
               || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        cfg_length = STREAM_LENGTH_RST;
        cfg_music  = 1'b1;
        cfg_voice  = VOICE_ID_RST;
        cfg_reverb = 7'd0;
        restart_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: extremes of data bytes, longest delta, no-result cases
        gap_max = 16;
        push_byte(8'h00, 1'b1);
        push_byte(status_byte(KIND_NOTE_ON, 4'h0));
        push_byte(8'h00);
        push_byte(8'hFF);
        repeat (4) push_byte(8'hFF);
        push_byte(status_byte(KIND_NOTE_OFF, 4'hF));
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(status_byte(KIND_BEND, 4'h9));
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(STATUS_META);
        push_byte(META_TEMPO);
        push_byte(TEMPO_LEN);
        repeat (3) push_byte(8'h00);
        push_byte(8'h00);
        push_byte(STATUS_META);
        push_byte(META_SEQ);
        push_byte(8'h04);
        push_byte(8'h00);
        push_byte(SEQ_JUMP);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(STATUS_META);
        push_byte(META_END);
        push_byte(8'h00);
        push_byte(8'h33);
        settle();

        // shortest stream: read past the end
        write_all(20'd1, 1'b0, 7'd127, 7'd127);
        push_byte(8'h00, 1'b1);
        push_byte(status_byte(KIND_NOTE_ON, 4'h3));
        push_byte(8'h12);
        settle();

        // event finishing exactly at the stream length
        write_all(20'd3, 1'b1, 7'd0, 7'd0);
        push_byte(8'h00, 1'b1);
        push_byte(status_byte(KIND_PROGRAM, 4'h5));
        push_byte(8'h7F);
        settle();

        write_all(STREAM_LENGTH_RST, 1'b1, 7'($urandom), 7'($urandom));
        random_phase(80, 16);
        settle();

        // back-pressure: sender streams without gaps while the receiver holds off
        write_all(STREAM_LENGTH_RST, 1'b0, 7'd0, 7'd127);
        random_phase(60, 0);
        holds_asked++;
        settle();

        write_all(20'($urandom_range(16, 80)), 1'($urandom), 7'($urandom), 7'($urandom));
        random_phase(70, 16);
        settle();

        write_all(20'($urandom_range(100, 1048575)), 1'b1, 7'd127, 7'd0);
        random_phase(80, -1);
        settle();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
